### rtl/core/audio_echo_mixer_top_defines.svh
// Assertion helpers shared by the RTL that checks itself.
// Both expect signals named clk and rst in the calling scope.
`ifndef AUDIO_ECHO_MIXER_TOP_DEFINES_SVH
`define AUDIO_ECHO_MIXER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AEM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### rtl/core/aem_pkg.sv
package aem_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 15;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_DELAY_DEFAULT = 16384;

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(8000);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4);

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b1;

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Serial divider: one quotient bit per cycle
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [DELAY_W-1:0] echo_lag;
    logic [SCALE_W-1:0] echo_div;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
  } job_t;

endpackage

### rtl/core/aem_front.sv
module aem_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic signed [aem_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aem_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aem_pkg::CFG_DATA_W-1:0]       cfg_data,
  output aem_pkg::cfg_t                        cfg,
  output logic                                 job_valid,
  output aem_pkg::job_t                        job,
  input  logic                                 job_ready
);

  assign cfg_ready = 1'b1;
  assign in_ready  = !job_valid || job_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_lag <= aem_pkg::DELAY_RESET;
      cfg.echo_div <= aem_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        aem_pkg::REG_DELAY: cfg.echo_lag <= cfg_data[aem_pkg::DELAY_W-1:0];
        aem_pkg::REG_SCALE: cfg.echo_div <= cfg_data[aem_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: classify the word, drain becomes a zero sample
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job.x <= (cmd == aem_pkg::CMD_DRAIN) ? '0 : sample;
    end
  end

endmodule

### rtl/core/aem_queue.sv
module aem_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  aem_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output aem_pkg::job_t pop_job
);

  aem_pkg::job_t                    slots [aem_pkg::QUEUE_DEPTH];
  logic [aem_pkg::QPTR_W-1:0]       wr_ptr;
  logic [aem_pkg::QPTR_W-1:0]       rd_ptr;
  logic [aem_pkg::QCNT_W-1:0]       count;
  logic                             push;
  logic                             pop;

  assign push_ready = (count != aem_pkg::QCNT_W'(aem_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  function automatic logic [aem_pkg::QPTR_W-1:0] bump(input logic [aem_pkg::QPTR_W-1:0] p);
    if (32'(p) == aem_pkg::QUEUE_DEPTH - 1) begin
      bump = '0;
    end else begin
      bump = p + 1'b1;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### rtl/core/aem_back.sv
module aem_back #(
  parameter int MAX_DELAY = aem_pkg::MAX_DELAY_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  aem_pkg::cfg_t                        cfg,
  input  logic                                 job_valid,
  output logic                                 job_ready,
  input  aem_pkg::job_t                        job,
  output logic                                 busy,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [aem_pkg::SAMPLE_W-1:0]  mixed
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int DW = $clog2(MAX_DELAY + 1);
  localparam int SW = aem_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DONE
  } state_t;

  state_t                           state;
  logic [SW-1:0]                    mem [MAX_DELAY];
  logic [SW-1:0]                    rdata;
  logic [AW-1:0]                    wp;
  logic                             wrapped;
  logic                             hit;
  logic signed [SW-1:0]             x;
  logic                             neg;
  logic [SW-1:0]                    quo;
  logic [SW-1:0]                    rem;
  logic [aem_pkg::DCNT_W-1:0]       cnt;

  logic [DW-1:0]                    d_eff;
  logic [aem_pkg::SCALE_W-1:0]      scale_eff;
  logic [AW:0]                      wp_ext;
  logic [AW:0]                      d_ext;
  logic [AW:0]                      rd_full;
  logic [AW-1:0]                    rd_addr;
  logic                             pop;
  logic [SW-1:0]                    delayed;
  logic [SW-1:0]                    mag;
  logic [SW:0]                      shifted;
  logic                             ge;
  logic [SW-1:0]                    q_signed;
  logic [SW-1:0]                    sum;

  // Effective delay: zero reads as one, beyond the depth saturates
  always_comb begin
    if (cfg.echo_lag == '0) begin
      d_eff = DW'(1);
    end else if (32'(cfg.echo_lag) > 32'(MAX_DELAY)) begin
      d_eff = DW'(MAX_DELAY);
    end else begin
      d_eff = DW'(cfg.echo_lag);
    end
  end

  assign scale_eff = (cfg.echo_div == '0) ? aem_pkg::SCALE_W'(1) : cfg.echo_div;

  // Read address: wp - d, modulo depth
  assign wp_ext = {1'b0, wp};
  assign d_ext  = (AW+1)'(d_eff);
  always_comb begin
    if (wp_ext >= d_ext) begin
      rd_full = wp_ext - d_ext;
    end else begin
      rd_full = wp_ext + (AW+1)'(MAX_DELAY) - d_ext;
    end
  end
  assign rd_addr = rd_full[AW-1:0];

  assign job_ready = (state == S_IDLE);
  assign pop       = job_valid && job_ready;
  assign busy      = (state != S_IDLE);

  // Entries not yet written since reset read as zero
  assign delayed = hit ? rdata : '0;
  assign mag     = delayed[SW-1] ? SW'(-delayed) : delayed;

  // Restoring divide step
  assign shifted = {rem, quo[SW-1]};
  assign ge      = (shifted >= (SW+1)'(scale_eff));

  assign q_signed = neg ? SW'(-quo) : quo;
  assign sum      = SW'(x) + q_signed;

  always_ff @(posedge clk) begin
    if (pop) begin
      mem[wp] <= SW'(job.x);
      rdata   <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            x   <= job.x;
            hit <= wrapped || (rd_addr < wp);
            if (32'(wp) == MAX_DELAY - 1) begin
              wp      <= '0;
              wrapped <= 1'b1;
            end else begin
              wp <= wp + 1'b1;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          neg   <= delayed[SW-1];
          quo   <= mag;
          rem   <= '0;
          cnt   <= aem_pkg::DCNT_W'(aem_pkg::DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem <= SW'(shifted - (SW+1)'(scale_eff));
          end else begin
            rem <= shifted[SW-1:0];
          end
          quo <= {quo[SW-2:0], ge};
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            mixed <= sum;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/audio_echo_mixer_top.sv
// Echo mixer for 16-bit signed PCM: each output word is the input sample plus
// the sample from echo_lag words earlier divided by echo_div (quotient
// truncated toward zero, sum wrapped to 16 bits). A drain word (cmd = 1) mixes
// as a zero sample and stores a zero, so software can flush the echo tail.
// Delay 0 acts as 1, delay above MAX_DELAY saturates to MAX_DELAY, divisor 0
// acts as 1. The back end takes each word through a read of the delay
// memory, a setup step, the bit-serial divider and a mix step, and takes
// no new word until that one is mixed, so the divider sets the sustained rate.
// A front register and a two-word queue take new words while the back end
// works, and the output register lets a finished word wait for its sink.
// The delay memory needs no clearing pass after reset: a wrap flag on the
// write pointer marks entries not yet written, which read as zero, so the
// block takes words straight out of reset. Config writes are accepted every
// cycle and must only be made while the block is idle.

`include "audio_echo_mixer_top_defines.svh"

module audio_echo_mixer_top #(
  parameter int MAX_DELAY = aem_pkg::MAX_DELAY_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic signed [aem_pkg::SAMPLE_W-1:0]  sample,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [aem_pkg::SAMPLE_W-1:0]  mixed,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aem_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aem_pkg::CFG_DATA_W-1:0]       cfg_data
);

  aem_pkg::cfg_t cfg;
  aem_pkg::job_t front_job;
  aem_pkg::job_t back_job;
  logic          front_valid;
  logic          q_in_ready;
  logic          q_out_valid;
  logic          back_ready;
  logic          back_busy;

  // Front: config registers and input register
  aem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sample    (sample),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .job_valid (front_valid),
    .job       (front_job),
    .job_ready (q_in_ready)
  );

  // Short queue decouples front and back
  aem_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (q_in_ready),
    .push_job   (front_job),
    .pop_valid  (q_out_valid),
    .pop_ready  (back_ready),
    .pop_job    (back_job)
  );

  // Back: delay memory, serial divider, mix and output register
  aem_back #(
    .MAX_DELAY (MAX_DELAY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (q_out_valid),
    .job_ready (back_ready),
    .job       (back_job),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mixed     (mixed)
  );

  // A result only appears at the end of a job in the back end
  `AEM_ASSERT_NOW(a_result_from_job, $rose(out_valid), $past(back_busy))
  // An accepted word lands in the front register
  `AEM_ASSERT_NEXT(a_front_capture, in_valid && in_ready, front_valid)
  // A front word blocked by a full queue is held unchanged
  `AEM_ASSERT_NEXT(a_front_hold, front_valid && !q_in_ready, front_valid && $stable(front_job))

endmodule
